/* src/pwwa_pkg.sv */
// Shared types and constants for the paired weighted window average block.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package pwwa_pkg;

	localparam int BIN_W     = 10;
	localparam int RATE_W    = 24;
	localparam int MEAN_W    = 24;
	localparam int DIV_STEPS = 24;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [2:0] ADDR_RANGE_FIRST = 3'd0;
	localparam logic [2:0] ADDR_RANGE_LAST  = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD_WR,
		ST_Q_RD_HI,
		ST_Q_RD_LO,
		ST_Q_SUB,
		ST_DIV,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic cap_load;
		logic cap_query;
		logic wr;
		logic rd_hi;
		logic rd_lo;
		logic sub;
		logic div_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic hit;
	} status_t;

endpackage

/* src/paired_weighted_window_average_top.sv */
// Top level of the paired weighted window average block.
// Depends on pwwa_pkg, pwwa_ctrl and pwwa_dp; holds the APB range registers.
`timescale 1ns / 1ps

// Usage: the input channel (in_valid / in_stall) carries one item per
// handshake. An item with operation set to load appends the next bin's two
// rate-weight products and two weights, if the bin qualifies, to the running
// prefix sums; once MAX_BINS bins are loaded, further loads are dropped. A
// load produces no result: the products are registered, then the new prefix
// entry is written into the single-port-write prefix memory.
// An item with operation set to query produces exactly one result item on
// the output channel (out_valid / out_stall): the queried bin, the two
// exposure-weighted means over the window of HALF_WINDOW bins each side,
// and a valid flag. A query runs from acceptance to the result register
// through two memory reads (window end, then entry before window start),
// a subtract step, 24 steps of the two radix-2 dividers running in
// parallel, then the output load. An empty or out-of-range window cuts the
// divide short to a single step.
// The result waits in an output register while out_stall is high; the
// block returns to idle and takes the next item once the result is loaded,
// so it takes no new item while a query is in progress.
// Reset clears the bin count and running sums and sets the range registers
// to 0 and 1023; the prefix memory itself is not cleared.
// Range registers are written over APB at byte addresses 0 and 4.

module paired_weighted_window_average_top
	import pwwa_pkg::*;
#(
	parameter int MAX_BINS    = 1024,
	parameter int HALF_WINDOW = 189
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              operation,
	input  logic [BIN_W-1:0]  query_bin,
	input  logic [RATE_W-1:0] rate_first,
	input  logic [RATE_W-1:0] rate_second,
	input  logic [RATE_W-1:0] weight_first,
	input  logic [RATE_W-1:0] weight_second,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [BIN_W-1:0]  result_bin,
	output logic [MEAN_W-1:0] mean_first,
	output logic [MEAN_W-1:0] mean_second,
	output logic              mean_valid,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	logic [BIN_W-1:0] range_first_q;
	logic [BIN_W-1:0] range_last_q;
	logic             cfg_wr;
	cmd_t             cmd;
	status_t          st;

	// The register file always answers in the access cycle.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_first_q <= '0;
			range_last_q  <= '1;
		end else if (cfg_wr) begin
			unique case (paddr)
				ADDR_RANGE_FIRST: range_first_q <= pwdata[BIN_W-1:0];
				ADDR_RANGE_LAST:  range_last_q  <= pwdata[BIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr)
			ADDR_RANGE_FIRST: prdata = 32'(range_first_q);
			ADDR_RANGE_LAST:  prdata = 32'(range_last_q);
			default:          prdata = '0;
		endcase
	end

	pwwa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.operation (operation),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.st        (st),
		.cmd       (cmd)
	);

	pwwa_dp #(.MAX_BINS(MAX_BINS), .HALF_WINDOW(HALF_WINDOW)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.range_first   (range_first_q),
		.range_last    (range_last_q),
		.query_bin     (query_bin),
		.rate_first    (rate_first),
		.rate_second   (rate_second),
		.weight_first  (weight_first),
		.weight_second (weight_second),
		.result_bin    (result_bin),
		.mean_first    (mean_first),
		.mean_second   (mean_second),
		.mean_valid    (mean_valid)
	);

endmodule

/* src/pwwa_div.sv */
// Restoring radix-2 divider, one quotient bit per step, 24-bit quotient.
// Depends on pwwa_pkg for the quotient width.
`timescale 1ns / 1ps

module pwwa_div
	import pwwa_pkg::*;
#(
	parameter int NUM_W = 58,
	parameter int DEN_W = 34
) (
	input  logic              clk,
	input  logic              load,
	input  logic              step,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	output logic [MEAN_W-1:0] quot
);

	localparam int SH_W = DEN_W + MEAN_W - 1;

	logic [NUM_W-1:0]  rem_q;
	logic [SH_W-1:0]   den_sh_q;
	logic [MEAN_W-1:0] quot_q;
	logic [NUM_W-1:0]  den_ext;
	logic              fits;

	// The mean never exceeds the largest rate, so the quotient fits 24 bits.
	assign den_ext = NUM_W'(den_sh_q);
	assign fits    = rem_q >= den_ext;

	always_ff @(posedge clk) begin
		if (load) begin
			rem_q    <= num;
			den_sh_q <= {den, {(MEAN_W-1){1'b0}}};
			quot_q   <= '0;
		end else if (step) begin
			if (fits) begin
				rem_q <= rem_q - den_ext;
			end
			quot_q   <= {quot_q[MEAN_W-2:0], fits};
			den_sh_q <= den_sh_q >> 1;
		end
	end

	assign quot = quot_q;

endmodule

/* src/pwwa_ctrl.sv */
// Controller state machine: sequences loads, memory reads and divisions.
// Depends on pwwa_pkg for the state, command and status types.
`timescale 1ns / 1ps

module pwwa_ctrl
	import pwwa_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    operation,
	output logic    in_stall,
	output logic    out_valid,
	input  logic    out_stall,
	input  status_t st,
	output cmd_t    cmd
);

	state_t           state_q, state_nx;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nx = (operation == OP_LOAD) ? ST_LOAD_WR : ST_Q_RD_HI;
				end
			end
			ST_LOAD_WR: state_nx = ST_IDLE;
			ST_Q_RD_HI: state_nx = ST_Q_RD_LO;
			ST_Q_RD_LO: state_nx = ST_Q_SUB;
			ST_Q_SUB:   state_nx = ST_DIV;
			ST_DIV: begin
				if (!st.hit || cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					state_nx = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd           = '0;
		cmd.cap_load  = (state_q == ST_IDLE) && in_valid && (operation == OP_LOAD);
		cmd.cap_query = (state_q == ST_IDLE) && in_valid && (operation == OP_QUERY);
		cmd.wr        = (state_q == ST_LOAD_WR) && !st.full;
		cmd.rd_hi     = (state_q == ST_Q_RD_HI);
		cmd.rd_lo     = (state_q == ST_Q_RD_LO);
		cmd.sub       = (state_q == ST_Q_SUB);
		cmd.div_step  = (state_q == ST_DIV);
		cmd.out_load  = (state_q == ST_OUT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_DIV) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else begin
				cnt_q <= '0;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

/* src/pwwa_dp.sv */
// Datapath: prefix-sum memory, running totals, window bounds, two dividers
// and the result register. Depends on pwwa_pkg and pwwa_div.
`timescale 1ns / 1ps

module pwwa_dp
	import pwwa_pkg::*;
#(
	parameter int MAX_BINS    = 1024,
	parameter int HALF_WINDOW = 189
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output status_t           st,
	input  logic [BIN_W-1:0]  range_first,
	input  logic [BIN_W-1:0]  range_last,
	input  logic [BIN_W-1:0]  query_bin,
	input  logic [RATE_W-1:0] rate_first,
	input  logic [RATE_W-1:0] rate_second,
	input  logic [RATE_W-1:0] weight_first,
	input  logic [RATE_W-1:0] weight_second,
	output logic [BIN_W-1:0]  result_bin,
	output logic [MEAN_W-1:0] mean_first,
	output logic [MEAN_W-1:0] mean_second,
	output logic              mean_valid
);

	localparam int LB   = $clog2(MAX_BINS);
	localparam int AW   = (LB < 1) ? 1 : LB;
	localparam int CW   = $clog2(MAX_BINS + 1);
	localparam int SW   = ((CW > BIN_W) ? CW : BIN_W) + 2;
	localparam int PW   = 2 * RATE_W + LB;
	localparam int WW   = RATE_W + LB;
	localparam int EW   = 2 * PW + 2 * WW;
	localparam int PW_W = 2 * RATE_W;

	// Entry layout: weighted first, weighted second, weight first, weight second.
	logic [EW-1:0] mem_q [MAX_BINS];
	logic [EW-1:0] rd_data_q;
	logic [EW-1:0] hi_data_q;
	logic [AW-1:0] rd_addr;

	logic [CW-1:0]    count_q;
	logic [PW-1:0]    acc_af_q, acc_as_q;
	logic [WW-1:0]    acc_bf_q, acc_bs_q;
	logic [PW_W-1:0]  prod_f_s1, prod_s_s1;
	logic [RATE_W-1:0] wf_s1, ws_s1;
	logic             qual_s1;

	logic [BIN_W-1:0] q_q, lo_q;
	logic [AW-1:0]    hi_q;
	logic             qok_q, lo_zero_q, hit_q;

	logic [PW-1:0] new_af, new_as;
	logic [WW-1:0] new_bf, new_bs;
	logic [SW-1:0] load_idx, qw, lastw, hiw, first_w, last_w;
	logic          load_in_range, qual;
	logic [BIN_W-1:0] lo_c, lo_m1;
	logic [EW-1:0] lo_data;
	logic [PW-1:0] d_af, d_as;
	logic [WW-1:0] d_bf, d_bs;
	logic [MEAN_W-1:0] quot_f, quot_s;

	// Load path: a qualifying bin adds its products and weights.
	assign first_w       = SW'(range_first);
	assign last_w        = SW'(range_last);
	assign load_idx      = SW'(count_q);
	assign load_in_range = (load_idx >= first_w) && (load_idx <= last_w);
	assign qual = load_in_range && (rate_first != '0) && (rate_second != '0)
		&& (weight_first != '0) && (weight_second != '0);

	assign new_af = qual_s1 ? acc_af_q + PW'(prod_f_s1) : acc_af_q;
	assign new_as = qual_s1 ? acc_as_q + PW'(prod_s_s1) : acc_as_q;
	assign new_bf = qual_s1 ? acc_bf_q + WW'(wf_s1) : acc_bf_q;
	assign new_bs = qual_s1 ? acc_bs_q + WW'(ws_s1) : acc_bs_q;

	// Query window bounds, clipped to the bins loaded so far.
	assign qw    = SW'(query_bin) + SW'(HALF_WINDOW);
	assign lastw = load_idx - SW'(1);
	assign hiw   = (qw > lastw) ? lastw : qw;
	assign lo_c  = (query_bin > BIN_W'(HALF_WINDOW)) ? query_bin - BIN_W'(HALF_WINDOW) : '0;
	assign lo_m1 = lo_q - BIN_W'(1);

	always_comb begin
		if (cmd.rd_lo) begin
			rd_addr = AW'(lo_m1);
		end else if (cmd.wr) begin
			rd_addr = AW'(count_q);
		end else begin
			rd_addr = hi_q;
		end
	end

	assign lo_data = lo_zero_q ? '0 : rd_data_q;
	assign d_af = hi_data_q[EW-1 -: PW] - lo_data[EW-1 -: PW];
	assign d_as = hi_data_q[EW-PW-1 -: PW] - lo_data[EW-PW-1 -: PW];
	assign d_bf = hi_data_q[2*WW-1 -: WW] - lo_data[2*WW-1 -: WW];
	assign d_bs = hi_data_q[WW-1:0] - lo_data[WW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem_q[rd_addr] <= {new_af, new_as, new_bf, new_bs};
		end
		rd_data_q <= mem_q[rd_addr];
		if (cmd.rd_lo) begin
			hi_data_q <= rd_data_q;
		end
		if (cmd.cap_load) begin
			prod_f_s1 <= rate_first * weight_first;
			prod_s_s1 <= rate_second * weight_second;
			wf_s1     <= weight_first;
			ws_s1     <= weight_second;
			qual_s1   <= qual;
		end
		if (cmd.cap_query) begin
			q_q       <= query_bin;
			lo_q      <= lo_c;
			lo_zero_q <= (lo_c == '0);
			hi_q      <= AW'(hiw);
			qok_q     <= (SW'(query_bin) < load_idx) && (query_bin >= range_first)
				&& (query_bin <= range_last);
		end
		if (cmd.sub) begin
			hit_q <= qok_q && (d_bf != '0) && (d_bs != '0);
		end
		if (cmd.out_load) begin
			result_bin  <= q_q;
			mean_first  <= hit_q ? quot_f : '0;
			mean_second <= hit_q ? quot_s : '0;
			mean_valid  <= hit_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			acc_af_q <= '0;
			acc_as_q <= '0;
			acc_bf_q <= '0;
			acc_bs_q <= '0;
		end else if (cmd.wr) begin
			count_q  <= count_q + CW'(1);
			acc_af_q <= new_af;
			acc_as_q <= new_as;
			acc_bf_q <= new_bf;
			acc_bs_q <= new_bs;
		end
	end

	pwwa_div #(.NUM_W(PW), .DEN_W(WW)) u_div_first (
		.clk  (clk),
		.load (cmd.sub),
		.step (cmd.div_step),
		.num  (d_af),
		.den  (d_bf),
		.quot (quot_f)
	);

	pwwa_div #(.NUM_W(PW), .DEN_W(WW)) u_div_second (
		.clk  (clk),
		.load (cmd.sub),
		.step (cmd.div_step),
		.num  (d_as),
		.den  (d_bs),
		.quot (quot_s)
	);

	assign st.full = (count_q == CW'(MAX_BINS));
	assign st.hit  = hit_q;

endmodule
